// File: rtl/grsr_pkg.sv
// ----------------------------------------------------------------------------
// grsr_pkg: shared types and helpers for the glyph row stretch/rounding block
// Beat structs, counter widths, default geometry and the pixel functions.
// ----------------------------------------------------------------------------
package grsr_pkg;

	localparam int ROWS_PER_GLYPH_DEF = 10;
	localparam int TEXT_GLYPHS_DEF    = 96;
	localparam int MOSAIC_GLYPHS_DEF  = 128;

	localparam int ROW_W       = 4;
	localparam int GLYPH_W     = 8;
	// glyph counter holds up to text + mosaic totals of 512
	localparam int GLYPH_CNT_W = 9;
	localparam int PIX_W       = 12;
	localparam int TEXT_BITS   = 5;
	localparam int MOSAIC_BITS = 6;

	typedef struct packed {
		logic [7:0] font_byte;
		logic       start_of_font;
	} in_beat_t;

	typedef struct packed {
		logic [PIX_W-1:0]   upper_row;
		logic [PIX_W-1:0]   lower_row;
		logic [GLYPH_W-1:0] glyph_number;
		logic [ROW_W-1:0]   row_number;
		logic               last;
	} out_beat_t;

	typedef struct packed {
		logic [TEXT_BITS-1:0]   held_row;
		logic [TEXT_BITS-1:0]   row_above_held;
		logic [GLYPH_CNT_W-1:0] glyph_cnt;
		logic [ROW_W-1:0]       row_cnt;
	} track_t;

	typedef struct packed {
		out_beat_t  first;
		out_beat_t  second;
		logic [1:0] count;
	} beat_pair_t;

	// each source pixel becomes two output pixels
	function automatic logic [PIX_W-1:0] stretch(input logic [MOSAIC_BITS-1:0] bits);
		logic [PIX_W-1:0] r;
		r = '0;
		for (int b = 0; b < MOSAIC_BITS; b++) begin
			r[2*b +: 2] = {2{bits[b]}};
		end
		return r;
	endfunction

	// half-pixel diagonal fill of row c against neighbor row d
	function automatic logic [PIX_W-1:0] rounding(input logic [TEXT_BITS-1:0] c,
		input logic [TEXT_BITS-1:0] d);
		logic [PIX_W-1:0] e;
		e = '0;
		if (c[4] && d[3] && !d[4]) e = e | 12'h080;
		if (c[3] && d[2] && !d[3]) e = e | 12'h020;
		if (c[2] && d[1] && !d[2]) e = e | 12'h008;
		if (c[1] && d[0] && !d[1]) e = e | 12'h002;
		if (d[4] && c[3] && !d[3]) e = e | 12'h100;
		if (d[3] && c[2] && !d[2]) e = e | 12'h040;
		if (d[2] && c[1] && !d[1]) e = e | 12'h010;
		if (d[1] && c[0] && !d[0]) e = e | 12'h004;
		return e;
	endfunction

endpackage

// File: rtl/grsr_calc.sv
// ----------------------------------------------------------------------------
// grsr_calc: per-row result and next-position logic
// Forms the zero, one or two result beats of one ROM row and the next state.
// ----------------------------------------------------------------------------
module grsr_calc #(
	parameter int ROWS_PER_GLYPH = grsr_pkg::ROWS_PER_GLYPH_DEF,
	parameter int TEXT_GLYPHS    = grsr_pkg::TEXT_GLYPHS_DEF,
	parameter int MOSAIC_GLYPHS  = grsr_pkg::MOSAIC_GLYPHS_DEF
) (
	input  grsr_pkg::in_beat_t   in_data,
	input  logic                 smooth,
	input  grsr_pkg::track_t     track,
	output grsr_pkg::beat_pair_t pair,
	output grsr_pkg::track_t     track_next
);
	localparam int CW    = grsr_pkg::GLYPH_CNT_W;
	localparam int RW    = grsr_pkg::ROW_W;
	localparam int TOTAL = TEXT_GLYPHS + MOSAIC_GLYPHS;

	grsr_pkg::track_t                cur;
	logic [grsr_pkg::TEXT_BITS-1:0]  c;
	logic                            is_text;
	logic                            emit_held;
	logic                            emit_cur;
	logic [RW:0]                     row_inc;
	logic [CW:0]                     glyph_inc;
	logic [grsr_pkg::PIX_W-1:0]      base_h;
	logic [grsr_pkg::PIX_W-1:0]      base_c;
	grsr_pkg::out_beat_t             held_beat;
	grsr_pkg::out_beat_t             cur_beat;
	grsr_pkg::out_beat_t             mos_beat;

	always_comb begin
		cur = track;
		if (in_data.start_of_font) begin
			cur = '0;
		end
		c         = in_data.font_byte[grsr_pkg::TEXT_BITS-1:0];
		is_text   = {1'b0, cur.glyph_cnt} < (CW+1)'(TEXT_GLYPHS);
		row_inc   = {1'b0, cur.row_cnt} + (RW+1)'(1);
		emit_held = is_text && (cur.row_cnt != '0);
		emit_cur  = is_text && (row_inc >= (RW+1)'(ROWS_PER_GLYPH));

		base_h = grsr_pkg::stretch({1'b0, cur.held_row});
		base_c = grsr_pkg::stretch({1'b0, c});

		held_beat.upper_row    = base_h;
		held_beat.lower_row    = base_h;
		if (smooth && cur.row_cnt != RW'(1)) begin
			held_beat.upper_row = base_h | grsr_pkg::rounding(cur.held_row, cur.row_above_held);
		end
		if (smooth) begin
			held_beat.lower_row = base_h | grsr_pkg::rounding(cur.held_row, c);
		end
		held_beat.glyph_number = cur.glyph_cnt[grsr_pkg::GLYPH_W-1:0];
		held_beat.row_number   = cur.row_cnt - RW'(1);
		held_beat.last         = !emit_cur;

		cur_beat.upper_row    = base_c;
		if (smooth && cur.row_cnt != '0) begin
			cur_beat.upper_row = base_c | grsr_pkg::rounding(c, cur.held_row);
		end
		cur_beat.lower_row    = base_c;
		cur_beat.glyph_number = cur.glyph_cnt[grsr_pkg::GLYPH_W-1:0];
		cur_beat.row_number   = cur.row_cnt;
		cur_beat.last         = 1'b1;

		mos_beat.upper_row    = grsr_pkg::stretch(in_data.font_byte[grsr_pkg::MOSAIC_BITS-1:0]);
		mos_beat.lower_row    = mos_beat.upper_row;
		mos_beat.glyph_number = cur.glyph_cnt[grsr_pkg::GLYPH_W-1:0];
		mos_beat.row_number   = cur.row_cnt;
		mos_beat.last         = 1'b1;

		// pack the beats so the first slot always holds the earliest one
		pair.second = cur_beat;
		if (!is_text) begin
			pair.first = mos_beat;
			pair.count = 2'd1;
		end else if (emit_held) begin
			pair.first = held_beat;
			pair.count = emit_cur ? 2'd2 : 2'd1;
		end else begin
			pair.first = cur_beat;
			pair.count = emit_cur ? 2'd1 : 2'd0;
		end

		track_next = cur;
		if (is_text) begin
			track_next.row_above_held = cur.held_row;
			track_next.held_row       = c;
		end
		glyph_inc = {1'b0, cur.glyph_cnt} + (CW+1)'(1);
		if (row_inc >= (RW+1)'(ROWS_PER_GLYPH)) begin
			track_next.row_cnt = '0;
			if (glyph_inc >= (CW+1)'(TOTAL)) begin
				track_next.glyph_cnt = '0;
			end else begin
				track_next.glyph_cnt = glyph_inc[CW-1:0];
			end
		end else begin
			track_next.row_cnt = row_inc[RW-1:0];
		end
	end

endmodule

// File: rtl/grsr_outbuf.sv
// ----------------------------------------------------------------------------
// grsr_outbuf: two-slot result register
// Holds the beats of one row and hands them out in order.
// ----------------------------------------------------------------------------
module grsr_outbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  grsr_pkg::beat_pair_t pair,
	output logic                 can_load,
	output logic                 out_valid,
	input  logic                 out_ready,
	output grsr_pkg::out_beat_t  out_data
);
	grsr_pkg::out_beat_t slot0_s1;
	grsr_pkg::out_beat_t slot1_s1;
	logic [1:0]          count_s1;
	logic                pop;

	assign out_valid = count_s1 != 2'd0;
	assign out_data  = slot0_s1;
	assign pop       = out_valid && out_ready;
	// a new row may land once at most one beat is left and it leaves now
	assign can_load  = (count_s1 == 2'd0) || (count_s1 == 2'd1 && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_s1 <= 2'd0;
		end else if (load) begin
			count_s1 <= pair.count;
		end else if (pop) begin
			count_s1 <= count_s1 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_s1 <= pair.first;
			slot1_s1 <= pair.second;
		end else if (pop) begin
			slot0_s1 <= slot1_s1;
		end
	end

endmodule

// File: rtl/glyph_row_stretch_rounding.sv
// ----------------------------------------------------------------------------
// glyph_row_stretch_rounding: character ROM row doubler with diagonal rounding
// Counts glyph and row position itself and widens each row for display.
// ----------------------------------------------------------------------------
// Usage:
//  in channel (in_valid/in_ready/in_data) takes one ROM row per beat;
//  start_of_font restarts the glyph and row count at glyph 0, row 0.
//  out channel (out_valid/out_ready/out_data) gives the stretched rows.
//  cfg_we/cfg_wdata write smoothing_enable; write it only while idle.
//  A result shows on out_valid in the cycle after its row is taken.
//  One row per cycle while out_ready is high. The last row of a text glyph
//  yields two beats, held row and itself, out of the two-slot result
//  register, so in_ready drops while the first of them leaves. Rows 1 to
//  ROWS_PER_GLYPH-1 of a text glyph emit the row before; row 0 emits nothing.
//  When the receiver stalls, the result register holds its beats and in_ready
//  stays low until the last pending beat leaves.
//  Reset clears the position, held rows, smoothing_enable and pending beats.
// ----------------------------------------------------------------------------
module glyph_row_stretch_rounding #(
	parameter int ROWS_PER_GLYPH = grsr_pkg::ROWS_PER_GLYPH_DEF,
	parameter int TEXT_GLYPHS    = grsr_pkg::TEXT_GLYPHS_DEF,
	parameter int MOSAIC_GLYPHS  = grsr_pkg::MOSAIC_GLYPHS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  grsr_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output grsr_pkg::out_beat_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);
	grsr_pkg::track_t     track_q;
	grsr_pkg::track_t     track_next;
	grsr_pkg::beat_pair_t pair;
	logic                 smooth_q;
	logic                 accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= 1'b0;
			track_q  <= '0;
		end else begin
			if (cfg_we) begin
				smooth_q <= cfg_wdata;
			end
			if (accept) begin
				track_q <= track_next;
			end
		end
	end

	grsr_calc #(
		.ROWS_PER_GLYPH(ROWS_PER_GLYPH),
		.TEXT_GLYPHS   (TEXT_GLYPHS),
		.MOSAIC_GLYPHS (MOSAIC_GLYPHS)
	) u_calc (
		.in_data   (in_data),
		.smooth    (smooth_q),
		.track     (track_q),
		.pair      (pair),
		.track_next(track_next)
	);

	grsr_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.pair     (pair),
		.can_load (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: regression for glyph_row_stretch_rounding
// Streams character ROM rows into the row doubler, keeps its own model of the
// glyph/row position, held rows and diagonal fill, and checks each output
// beat in order against it. Covers smoothing on and off, restarts and a long
// pass from glyph 0 through every text glyph into the mosaic glyphs.
// ----------------------------------------------------------------------------
module tb;

	localparam int ROWS_N        = grsr_pkg::ROWS_PER_GLYPH_DEF;
	localparam int TEXT_N        = grsr_pkg::TEXT_GLYPHS_DEF;
	localparam int MOSAIC_N      = grsr_pkg::MOSAIC_GLYPHS_DEF;
	// all text rows plus the first rows of the mosaic set
	localparam int PASS_ROWS     = ROWS_N * TEXT_N + 16;
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_REPORTS   = 200;
	localparam int LIMIT_CYCLES  = 300000;

	class glyph_scoreboard;
		bit                  smooth = 1'b0;
		logic [4:0]          held = '0;
		logic [4:0]          above = '0;
		int                  glyph_pos = 0;
		int                  row_pos = 0;
		grsr_pkg::out_beat_t pending[$];
		int                  errors = 0;
		int                  rows_taken = 0;
		int                  restarts = 0;
		int                  text_beats = 0;
		int                  mosaic_beats = 0;

		function logic [11:0] doubled(logic [5:0] bits);
			logic [11:0] r;
			for (int i = 0; i < 6; i++) r[2*i +: 2] = {bits[i], bits[i]};
			return r;
		endfunction

		// half-pixel fill where one row steps diagonally past its neighbor
		function logic [11:0] corner_fill(logic [4:0] c, logic [4:0] d);
			logic [11:0] e;
			e = '0;
			for (int i = 0; i < 4; i++) begin
				if (c[i+1] && d[i] && !d[i+1]) e[2*i+1] = 1'b1;
				if (d[i+1] && c[i] && !d[i]) e[2*i+2] = 1'b1;
			end
			return e;
		endfunction

		function void note_row(grsr_pkg::in_beat_t b);
			logic [4:0]          cur;
			logic [11:0]         plain;
			grsr_pkg::out_beat_t made[2];
			int                  n;
			cur = b.font_byte[4:0];
			n = 0;
			rows_taken++;
			if (b.start_of_font) begin
				glyph_pos = 0;
				row_pos = 0;
				held = '0;
				above = '0;
				restarts++;
			end
			if (glyph_pos < TEXT_N) begin
				// held row goes out once the row below it is known
				if (row_pos > 0) begin
					plain = doubled({1'b0, held});
					made[n].upper_row = plain |
						((smooth && row_pos != 1) ? corner_fill(held, above) : 12'h000);
					made[n].lower_row = plain | (smooth ? corner_fill(held, cur) : 12'h000);
					made[n].glyph_number = 8'(glyph_pos);
					made[n].row_number = 4'(row_pos - 1);
					made[n].last = 1'b0;
					n++;
				end
				// bottom row of the glyph: no row below, lower line stays plain
				if (row_pos == ROWS_N - 1) begin
					plain = doubled({1'b0, cur});
					made[n].upper_row = plain |
						((smooth && row_pos != 0) ? corner_fill(cur, held) : 12'h000);
					made[n].lower_row = plain;
					made[n].glyph_number = 8'(glyph_pos);
					made[n].row_number = 4'(row_pos);
					made[n].last = 1'b0;
					n++;
				end
				above = held;
				held = cur;
			end else begin
				plain = doubled(b.font_byte[5:0]);
				made[n].upper_row = plain;
				made[n].lower_row = plain;
				made[n].glyph_number = 8'(glyph_pos);
				made[n].row_number = 4'(row_pos);
				made[n].last = 1'b0;
				n++;
			end
			if (n > 0) made[n-1].last = 1'b1;
			for (int k = 0; k < n; k++) pending.push_back(made[k]);
			row_pos++;
			if (row_pos >= ROWS_N) begin
				row_pos = 0;
				glyph_pos++;
				if (glyph_pos >= TEXT_N + MOSAIC_N) glyph_pos = 0;
			end
		endfunction

		task report_mismatch(string what);
			if (errors < MAX_REPORTS) $display("mismatch: %s", what);
			errors++;
		endtask

		task check_beat(grsr_pkg::out_beat_t got);
			grsr_pkg::out_beat_t want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("beat with nothing pending: %h", got));
				return;
			end
			want = pending.pop_front();
			if (got.upper_row !== want.upper_row)
				report_mismatch($sformatf("glyph %0d row %0d upper_row %h, want %h",
					want.glyph_number, want.row_number, got.upper_row, want.upper_row));
			if (got.lower_row !== want.lower_row)
				report_mismatch($sformatf("glyph %0d row %0d lower_row %h, want %h",
					want.glyph_number, want.row_number, got.lower_row, want.lower_row));
			if (got.glyph_number !== want.glyph_number)
				report_mismatch($sformatf("glyph_number %0d, want %0d",
					got.glyph_number, want.glyph_number));
			if (got.row_number !== want.row_number)
				report_mismatch($sformatf("glyph %0d row_number %0d, want %0d",
					want.glyph_number, got.row_number, want.row_number));
			if (got.last !== want.last)
				report_mismatch($sformatf("glyph %0d row %0d last %b, want %b",
					want.glyph_number, want.row_number, got.last, want.last));
			if (want.glyph_number < TEXT_N) text_beats++;
			else mosaic_beats++;
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	grsr_pkg::in_beat_t  in_data;
	logic                out_valid;
	logic                out_ready;
	grsr_pkg::out_beat_t out_data;
	logic                cfg_we;
	logic                cfg_wdata;

	glyph_scoreboard sb;
	int send_idle_pct = 7;
	int recv_idle_pct = 56;
	int hold_cycles = 0;

	glyph_row_stretch_rounding dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#(LIMIT_CYCLES * 12);
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: random stalls, plus long hold-offs counted here
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_beat(out_data);
	end

	// called at a falling edge, returns at a falling edge
	task offer_row(input bit restart, input logic [7:0] font);
		grsr_pkg::in_beat_t b;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		b.font_byte = font;
		b.start_of_font = restart;
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_row(b);
		@(negedge clk);
	endtask

	// a text row 0 leaves nothing pending, so allow some extra cycles
	task settle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task write_smoothing(input bit value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.smooth = value;
	endtask

	initial begin
		logic [7:0] prev_byte;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		sb = new;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// glyph 0: first row only held, unused high bits, dense and sparse rows
		write_smoothing(1'b1);
		offer_row(1'b1, 8'h04);
		offer_row(1'b0, 8'h0A);
		offer_row(1'b0, 8'h11);
		offer_row(1'b0, 8'h1F);
		offer_row(1'b0, 8'hE0);
		offer_row(1'b0, 8'hFF);
		offer_row(1'b0, 8'h15);
		offer_row(1'b0, 8'h0E);
		offer_row(1'b0, 8'h1B);
		// smoothing flips before the held row is emitted
		settle();
		write_smoothing(1'b0);
		offer_row(1'b0, 8'h04);
		offer_row(1'b0, 8'h1F);
		offer_row(1'b0, 8'h00);
		offer_row(1'b0, 8'h1F);
		offer_row(1'b0, 8'h55);
		// restart in the middle of glyph 1 drops the held row
		offer_row(1'b1, 8'hAA);
		settle();
		write_smoothing(1'b1);
		// staircase rows fire every diagonal fill
		for (int k = 0; k < 9; k++)
			offer_row(1'b0, (k < 5) ? (8'h01 << k) : (8'h10 >> (k - 4)));

		// one pass over every text glyph and on into the mosaic set
		settle();
		prev_byte = '0;
		for (int n = 0; n < PASS_ROWS; n++) begin
			if (n == 325) begin
				settle();
				write_smoothing(1'b0);
				send_idle_pct = 56;
				recv_idle_pct = 7;
			end
			if (n == 650) begin
				settle();
				write_smoothing(1'b1);
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (n == 200 || n == 700) hold_cycles = 60;
			if (n == 850) settle();
			// shifted copies of the last row make diagonals likely
			case ($urandom_range(0, 3))
				0: prev_byte = {prev_byte[6:0], 1'($urandom_range(0, 1))};
				1: prev_byte = {1'($urandom_range(0, 1)), prev_byte[7:1]};
				default: prev_byte = 8'($urandom_range(0, 255));
			endcase
			offer_row(n == 0, prev_byte);
		end

		// noisy tail with frequent restarts
		for (int n = 0; n < 100; n++)
			offer_row($urandom_range(0, 5) == 0, 8'($urandom_range(0, 255)));

		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		$display("run: %0d ROM rows, %0d restarts, all text glyphs into mosaic, smoothing on/off",
			sb.rows_taken, sb.restarts);
		$display("run: %0d text and %0d mosaic beats checked, %0d mismatches",
			sb.text_beats, sb.mosaic_beats, sb.errors);
		if (sb.errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule
